// ===== rtl/asdn_pkg.sv =====
// Shared types, widths and register codes for the box signed-distance block.
package asdn_pkg;

  localparam int COORD_BITS = 32;
  localparam int RAD_W      = COORD_BITS - 1;
  localparam int SLACK_W    = COORD_BITS + 2;
  localparam int DIST_W     = COORD_BITS + 3;
  localparam int MAG_W      = COORD_BITS + 1;
  localparam int ROOT_W     = MAG_W + 1;
  localparam int LEN_W      = ROOT_W + 1;
  localparam int SQ_W       = 2 * MAG_W + 4;
  localparam int DREM_W     = LEN_W + 1;
  localparam int NRM_W      = 16;
  localparam int Q_STEPS    = 15;
  localparam int Q_W        = Q_STEPS + 1;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = QPTR_W + 1;
  localparam logic [NRM_W-1:0] ONE_Q14 = NRM_W'(16384);

  typedef enum logic [2:0] {
    REG_MIN_X,
    REG_MIN_Y,
    REG_MIN_Z,
    REG_MAX_X,
    REG_MAX_Y,
    REG_MAX_Z,
    REG_INSIDE_POS
  } reg_idx_t;

  // Classified item: face results are final, edge items carry axis magnitudes.
  typedef struct packed {
    logic                          edge_case;
    logic                          fully;
    logic                          ip;
    logic [DIST_W-1:0]             face_dist;
    logic [2:0][NRM_W-1:0]         nrm;
    logic [2:0]                    vpos;
    logic [2:0]                    vneg;
    logic [2:0][MAG_W-1:0]         mag;
  } item_t;

  function automatic logic signed [SLACK_W-1:0] sx(input logic [COORD_BITS-1:0] v);
    sx = $signed({{(SLACK_W-COORD_BITS){v[COORD_BITS-1]}}, v});
  endfunction

endpackage

// ===== rtl/asdn_front.sv =====
// Front end: box registers, face slacks and item classification.
module asdn_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [2:0]                       wr_index,
  input  logic [asdn_pkg::COORD_BITS-1:0]  wr_data,
  input  logic [asdn_pkg::COORD_BITS-1:0]  point_x,
  input  logic [asdn_pkg::COORD_BITS-1:0]  point_y,
  input  logic [asdn_pkg::COORD_BITS-1:0]  point_z,
  input  logic [asdn_pkg::RAD_W-1:0]       radius,
  output asdn_pkg::item_t                  item
);
  import asdn_pkg::*;

  logic [COORD_BITS-1:0] lo [0:2];
  logic [COORD_BITS-1:0] hi [0:2];
  logic                  inside_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        lo[a] <= -COORD_BITS'(65536);
        hi[a] <= COORD_BITS'(65536);
      end
      inside_pos <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_MIN_X:      lo[0] <= wr_data;
        REG_MIN_Y:      lo[1] <= wr_data;
        REG_MIN_Z:      lo[2] <= wr_data;
        REG_MAX_X:      hi[0] <= wr_data;
        REG_MAX_Y:      hi[1] <= wr_data;
        REG_MAX_Z:      hi[2] <= wr_data;
        REG_INSIDE_POS: inside_pos <= wr_data[0];
        default: ;
      endcase
    end
  end

  logic [COORD_BITS-1:0]     pt [0:2];
  logic signed [SLACK_W-1:0] slk [0:5];
  logic signed [SLACK_W-1:0] rad;
  logic [5:0]                neg;
  logic [2:0]                cnt;
  logic [2:0]                face;
  logic [2:0]                last;
  logic [NRM_W-1:0]          fnrm;

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;
  assign rad   = $signed({{(SLACK_W-RAD_W){1'b0}}, radius});

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      slk[2*a]   = sx(pt[a]) - rad - sx(lo[a]);
      slk[2*a+1] = sx(hi[a]) - sx(pt[a]) - rad;
    end
    for (int k = 0; k < 6; k++) neg[k] = slk[k][SLACK_W-1];
    cnt  = 3'($countones(neg));
    last = '0;
    for (int k = 0; k < 6; k++) if (neg[k]) last = 3'(k);
    // smallest slack, first index wins on ties
    face = '0;
    for (int k = 1; k < 6; k++) if (slk[k] < slk[face]) face = 3'(k);
    if (cnt != 3'd0) face = last;

    item           = '0;
    item.ip        = inside_pos;
    item.fully     = (cnt == 3'd0);
    item.edge_case = (cnt > 3'd1);
    item.face_dist = inside_pos ? DIST_W'(slk[face]) : -DIST_W'(slk[face]);
    fnrm           = (face[0] ^ !inside_pos) ? -ONE_Q14 : ONE_Q14;
    item.nrm[face[2:1]] = fnrm;
    for (int a = 0; a < 3; a++) begin
      if (neg[2*a]) begin
        item.vneg[a] = 1'b1;
        item.mag[a]  = MAG_W'(-slk[2*a]);
      end else if (neg[2*a+1]) begin
        item.vpos[a] = 1'b1;
        item.mag[a]  = MAG_W'(-slk[2*a+1]);
      end
    end
  end

endmodule

// ===== rtl/asdn_queue.sv =====
// Short item queue between the front end and the back end.
module asdn_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  asdn_pkg::item_t wr_item,
  output logic            full,
  input  logic            rd,
  output asdn_pkg::item_t rd_item,
  output logic            nonempty
);
  import asdn_pkg::*;

  item_t             mem [0:QDEPTH-1];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] cnt;

  assign full     = (cnt == QCNT_W'(QDEPTH));
  assign nonempty = (cnt != '0);
  assign rd_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      cnt <= cnt + QCNT_W'(wr) - QCNT_W'(rd);
    end
  end

endmodule

// ===== rtl/asdn_back.sv =====
// Back end: squares, pipelined square root, unit-vector division, result register.
module asdn_back (
  input  logic                             clk,
  input  logic                             rst,
  input  asdn_pkg::item_t                  in_item,
  input  logic                             in_valid,
  output logic                             in_take,
  output logic [asdn_pkg::DIST_W-1:0]      distance,
  output logic [asdn_pkg::NRM_W-1:0]       normal_x,
  output logic [asdn_pkg::NRM_W-1:0]       normal_y,
  output logic [asdn_pkg::NRM_W-1:0]       normal_z,
  output logic                             fully_inside,
  output logic                             empty,
  input  logic                             pop
);
  import asdn_pkg::*;

  logic en;
  logic ov;

  assign en      = !ov || pop;
  assign in_take = en && in_valid;
  assign empty   = !ov;

  // operand and squares
  logic                 v0, v1;
  item_t                it0, it1;
  logic [2*MAG_W-1:0]   sq1 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0 <= in_item;
      it1 <= it0;
      for (int a = 0; a < 3; a++) sq1[a] <= it0.mag[a] * it0.mag[a];
    end
  end

  // square root, one root bit per stage; stage 0 holds the sum of squares
  logic              sv    [0:ROOT_W];
  item_t             sit   [0:ROOT_W];
  logic [SQ_W-1:0]   srem  [0:ROOT_W];
  logic [ROOT_W-1:0] sroot [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (en) sv[0] <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sit[0]   <= it1;
      srem[0]  <= SQ_W'(sq1[0]) + SQ_W'(sq1[1]) + SQ_W'(sq1[2]);
      sroot[0] <= '0;
    end
  end

  for (genvar g = 1; g <= ROOT_W; g++) begin : g_sqrt
    localparam int B = ROOT_W - g;
    logic [SQ_W-1:0] trial;
    assign trial = (SQ_W'(sroot[g-1]) << (B + 1)) + (SQ_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) sv[g] <= 1'b0;
      else if (en) sv[g] <= sv[g-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sit[g] <= sit[g-1];
        if (srem[g-1] >= trial) begin
          srem[g]  <= srem[g-1] - trial;
          sroot[g] <= sroot[g-1] | (ROOT_W'(1) << B);
        end else begin
          srem[g]  <= srem[g-1];
          sroot[g] <= sroot[g-1];
        end
      end
    end
  end

  // round to nearest: S > r*r + r means round up
  logic             lv;
  item_t            lit;
  logic [LEN_W-1:0] len;

  always_ff @(posedge clk) begin
    if (rst) lv <= 1'b0;
    else if (en) lv <= sv[ROOT_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lit <= sit[ROOT_W];
      len <= LEN_W'(sroot[ROOT_W]) +
             LEN_W'(srem[ROOT_W] > SQ_W'(sroot[ROOT_W]));
    end
  end

  // restoring division mag * 32768 / len, three lanes
  logic              dv   [0:Q_STEPS];
  item_t             dit  [0:Q_STEPS];
  logic [LEN_W-1:0]  dlen [0:Q_STEPS];
  logic [DREM_W-1:0] drem [0:Q_STEPS][0:2];
  logic [Q_W-1:0]    dq   [0:Q_STEPS][0:2];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= lv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dit[0]  <= lit;
      dlen[0] <= len;
      for (int a = 0; a < 3; a++) begin
        if (DREM_W'(lit.mag[a]) >= DREM_W'(len)) begin
          drem[0][a] <= DREM_W'(lit.mag[a]) - DREM_W'(len);
          dq[0][a]   <= Q_W'(1);
        end else begin
          drem[0][a] <= DREM_W'(lit.mag[a]);
          dq[0][a]   <= '0;
        end
      end
    end
  end

  for (genvar g = 1; g <= Q_STEPS; g++) begin : g_div
    logic [DREM_W-1:0] r2 [0:2];
    always_comb begin
      for (int a = 0; a < 3; a++) r2[a] = drem[g-1][a] << 1;
    end

    always_ff @(posedge clk) begin
      if (rst) dv[g] <= 1'b0;
      else if (en) dv[g] <= dv[g-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dit[g]  <= dit[g-1];
        dlen[g] <= dlen[g-1];
        for (int a = 0; a < 3; a++) begin
          if (r2[a] >= DREM_W'(dlen[g-1])) begin
            drem[g][a] <= r2[a] - DREM_W'(dlen[g-1]);
            dq[g][a]   <= {dq[g-1][a][Q_W-2:0], 1'b1};
          end else begin
            drem[g][a] <= r2[a];
            dq[g][a]   <= {dq[g-1][a][Q_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // result register
  item_t            fit;
  logic [Q_W:0]     qr [0:2];
  logic [NRM_W-1:0] um [0:2];
  logic [NRM_W-1:0] en_nrm [0:2];
  logic [DIST_W-1:0] edist;

  always_comb begin
    fit   = dit[Q_STEPS];
    edist = DIST_W'(dlen[Q_STEPS]);
    if (fit.ip) edist = -edist;
    for (int a = 0; a < 3; a++) begin
      qr[a] = (Q_W+1)'(dq[Q_STEPS][a]) + 1'b1;
      um[a] = qr[a][Q_W:1];
      if (fit.vpos[a])      en_nrm[a] = fit.ip ? -um[a] : um[a];
      else if (fit.vneg[a]) en_nrm[a] = fit.ip ? um[a] : -um[a];
      else                  en_nrm[a] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (en) ov <= dv[Q_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fully_inside <= fit.fully;
      if (fit.edge_case) begin
        distance <= edist;
        normal_x <= en_nrm[0];
        normal_y <= en_nrm[1];
        normal_z <= en_nrm[2];
      end else begin
        distance <= fit.face_dist;
        normal_x <= fit.nrm[0];
        normal_y <= fit.nrm[1];
        normal_z <= fit.nrm[2];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (lv && lit.edge_case) |-> (len != '0))
    else $error("edge item with zero length");

  a_face_single: assert property (@(posedge clk) disable iff (rst)
    (ov && fully_inside) |->
      ($countones({normal_x != '0, normal_y != '0, normal_z != '0}) == 1))
    else $error("inside item without a single face normal");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (ov && !pop) |=> (ov && $stable(distance) && $stable(normal_x)))
    else $error("waiting result changed before pop");

  // face results do not use the length; only edge items use the quotients
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    (dv[Q_STEPS] && fit.edge_case) |->
      (um[0] <= ONE_Q14 && um[1] <= ONE_Q14 && um[2] <= ONE_Q14))
    else $error("normal magnitude above one");
`endif

endmodule

// ===== rtl/aabb_signed_distance_normal.sv =====
// Top level: signed distance and contact normal from a point to an axis-aligned box.
// Throughput: one item per cycle; the back-end pipeline advances as one unit,
// held only while the result register waits on pop; a 4-item queue parts it from push.
// Reset (rst, synchronous) empties queue and pipeline and loads the box to +/-1.0,
// with positive distance inside.
module aabb_signed_distance_normal (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [2:0]                       wr_index,
  input  logic [asdn_pkg::COORD_BITS-1:0]  wr_data,
  input  logic                             push,
  output logic                             full,
  input  logic [asdn_pkg::COORD_BITS-1:0]  point_x,
  input  logic [asdn_pkg::COORD_BITS-1:0]  point_y,
  input  logic [asdn_pkg::COORD_BITS-1:0]  point_z,
  input  logic [asdn_pkg::RAD_W-1:0]       radius,
  output logic                             empty,
  input  logic                             pop,
  output logic [asdn_pkg::DIST_W-1:0]      distance,
  output logic [asdn_pkg::NRM_W-1:0]       normal_x,
  output logic [asdn_pkg::NRM_W-1:0]       normal_y,
  output logic [asdn_pkg::NRM_W-1:0]       normal_z,
  output logic                             fully_inside
);
  import asdn_pkg::*;

  item_t fr_item;
  item_t q_item;
  logic  q_nonempty;
  logic  q_take;

  asdn_front u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .radius   (radius),
    .item     (fr_item)
  );

  asdn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (push && !full),
    .wr_item  (fr_item),
    .full     (full),
    .rd       (q_take),
    .rd_item  (q_item),
    .nonempty (q_nonempty)
  );

  asdn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_item      (q_item),
    .in_valid     (q_nonempty),
    .in_take      (q_take),
    .distance     (distance),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .fully_inside (fully_inside),
    .empty        (empty),
    .pop          (pop)
  );

endmodule

// ===== test/tb.sv =====
// Testbench for the box signed-distance block: directed table plus random items vs a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import asdn_pkg::*;

  typedef struct {
    logic [DIST_W-1:0] sdist;
    logic [NRM_W-1:0]  nx, ny, nz;
    logic              fully;
  } contact_t;

  typedef struct {
    logic [COORD_BITS-1:0] px, py, pz;
    logic [RAD_W-1:0]      rad;
    bit                    typed;
    contact_t              res;
  } row_t;

  logic clk = 0, rst = 1;
  logic wr_en = 0;
  logic [2:0] wr_index = '0;
  logic [COORD_BITS-1:0] wr_data = '0;
  logic push = 0, pop = 0;
  logic full, empty, fully_inside;
  logic [COORD_BITS-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic [RAD_W-1:0] radius = '0;
  logic [DIST_W-1:0] distance;
  logic [NRM_W-1:0] normal_x, normal_y, normal_z;

  aabb_signed_distance_normal dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow of the box registers
  logic signed [COORD_BITS-1:0] bmin [3];
  logic signed [COORD_BITS-1:0] bmax [3];
  logic pos_inside;
  contact_t pending [$];
  int errors = 0;
  longint cycles = 0;
  int pop_gap = 0;

  function automatic logic [63:0] isqrt_round(logic [127:0] s);
    logic [63:0] r, c;
    r = 0;
    for (int b = 51; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= s) r = c;
    end
    if (s > 128'(r) * 128'(r) + 128'(r)) r = r + 1;
    return r;
  endfunction

  function automatic longint unit_q14(longint m, longint l);
    logic [127:0] num;
    num = 128'(m) * 128'(32768);
    return longint'((num / 128'(l) + 1) >> 1);
  endfunction

  function automatic contact_t predict_contact(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                                              logic [COORD_BITS-1:0] pz, logic [RAD_W-1:0] rad);
    longint p [3], sl [6], v [3], nrm [3], d, s, len, m;
    logic [127:0] sq;
    int cnt, last, face;
    contact_t r;
    p[0] = longint'($signed(px)); p[1] = longint'($signed(py)); p[2] = longint'($signed(pz));
    s = pos_inside ? 1 : -1;
    cnt = 0; last = 0;
    nrm = '{0, 0, 0};
    r.fully = 0;
    for (int a = 0; a < 3; a++) begin
      sl[2*a] = (p[a] - longint'(rad)) - longint'(bmin[a]);
      sl[2*a+1] = longint'(bmax[a]) - (p[a] + longint'(rad));
    end
    for (int k = 0; k < 6; k++) if (sl[k] < 0) begin cnt++; last = k; end
    if (cnt <= 1) begin
      face = last;
      if (cnt == 0) begin
        face = 0;
        for (int k = 1; k < 6; k++) if (sl[k] < sl[face]) face = k;
        r.fully = 1;
      end
      d = s * sl[face];
      nrm[face>>1] = s * ((face & 1) ? -16384 : 16384);
    end else begin
      sq = 0;
      for (int a = 0; a < 3; a++) begin
        if (sl[2*a] < 0) v[a] = sl[2*a];
        else if (sl[2*a+1] < 0) v[a] = -sl[2*a+1];
        else v[a] = 0;
        m = v[a] < 0 ? -v[a] : v[a];
        sq += 128'(m) * 128'(m);
      end
      len = longint'(isqrt_round(sq));
      d = -s * len;
      for (int a = 0; a < 3; a++) begin
        m = v[a] < 0 ? -v[a] : v[a];
        if (v[a] > 0) nrm[a] = -s * unit_q14(m, len);
        else if (v[a] < 0) nrm[a] = s * unit_q14(m, len);
      end
    end
    r.sdist = DIST_W'(d);
    r.nx = NRM_W'(nrm[0]); r.ny = NRM_W'(nrm[1]); r.nz = NRM_W'(nrm[2]);
    return r;
  endfunction

  // one write, then wr_en is dropped and the task waits on the clock again so the next drive lands in a later step
  task automatic write_reg(reg_idx_t idx, logic [COORD_BITS-1:0] val);
    wr_en <= 1; wr_index <= idx; wr_data <= val;
    @(posedge clk);
    case (idx)
      REG_MIN_X, REG_MIN_Y, REG_MIN_Z: bmin[int'(idx)] = val;
      REG_MAX_X, REG_MAX_Y, REG_MAX_Z: bmax[int'(idx) - 3] = val;
      default: pos_inside = val[0];
    endcase
    wr_en <= 0;
    @(posedge clk);
  endtask

  // one item through the push side; waits out full; push stays high for back-to-back items
  task automatic send_point(row_t rw);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
    push <= 1; point_x <= rw.px; point_y <= rw.py; point_z <= rw.pz; radius <= rw.rad;
    do @(posedge clk); while (full);
    pending.push_back(rw.typed ? rw.res : predict_contact(rw.px, rw.py, rw.pz, rw.rad));
  endtask

  task automatic drain;
    push <= 0;
    while (pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {1'b1, {(COORD_BITS-1){1'b0}}};
      2: return {1'b0, {(COORD_BITS-1){1'b1}}};
      default: return COORD_BITS'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
    endcase
  endfunction

  function automatic logic [RAD_W-1:0] rnd_rad();
    case ($urandom_range(0, 5))
      0: return RAD_W'($urandom());
      1: return {RAD_W{1'b1}};
      2: return '0;
      default: return RAD_W'($urandom_range(0, 1 << 16));
    endcase
  endfunction

  // pop side with random stalls, compare against oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (pending.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          contact_t e;
          e = pending.pop_front();
          if (distance !== e.sdist) begin
            $error("distance exp %h got %h", e.sdist, distance); errors++;
          end
          if (normal_x !== e.nx) begin
            $error("normal_x exp %h got %h", e.nx, normal_x); errors++;
          end
          if (normal_y !== e.ny) begin
            $error("normal_y exp %h got %h", e.ny, normal_y); errors++;
          end
          if (normal_z !== e.nz) begin
            $error("normal_z exp %h got %h", e.nz, normal_z); errors++;
          end
          if (fully_inside !== e.fully) begin
            $error("fully_inside exp %b got %b", e.fully, fully_inside); errors++;
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        pop <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
        pop_gap <= ($urandom_range(0, 12) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        pop <= 0;
      end else begin
        pop <= 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  localparam logic [COORD_BITS-1:0] ONE = 32'h0001_0000;
  localparam logic [COORD_BITS-1:0] CMAX = 32'h7FFF_FFFF;
  localparam logic [COORD_BITS-1:0] CMIN = 32'h8000_0000;

  initial begin
    row_t tbl [$];
    row_t rw;
    logic [COORD_BITS-1:0] lo, hi;
    bmin = '{-ONE, -ONE, -ONE};
    bmax = '{ONE, ONE, ONE};
    pos_inside = 1;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // after reset: centre, distance +1.0 on the -x face... lowest index wins ties
    tbl.push_back('{'0, '0, '0, '0, 1, '{DIST_W'(65536), NRM_W'(16384), '0, '0, 1}});
    // one face outside on +x by 1.0
    tbl.push_back('{2*ONE, '0, '0, '0, 1, '{-DIST_W'(65536), -NRM_W'(16384), '0, '0, 0}});
    // edge 3-4-5 triangle in x,y
    tbl.push_back('{4*ONE, 5*ONE, '0, '0, 1,
                    '{-DIST_W'(5*65536), -NRM_W'(9830), -NRM_W'(13107), '0, 0}});
    tbl.push_back('{CMAX, CMAX, CMAX, '0, 0, '{default: '0}});
    tbl.push_back('{CMIN, CMIN, CMIN, {RAD_W{1'b1}}, 0, '{default: '0}});
    tbl.push_back('{CMIN, CMAX, '0, {RAD_W{1'b1}}, 0, '{default: '0}});
    tbl.push_back('{'0, '0, '0, RAD_W'(2*ONE), 0, '{default: '0}});  // both faces of all axes
    tbl.push_back('{'0, '0, '0, RAD_W'(ONE), 0, '{default: '0}});    // zero slacks
    tbl.push_back('{'0, ONE/2, -ONE/2, RAD_W'(ONE/4), 0, '{default: '0}});
    tbl.push_back('{-2*ONE, -2*ONE, -2*ONE, '0, 0, '{default: '0}});  // corner
    tbl.push_back('{'0, '0, 3*ONE, '0, 0, '{default: '0}});
    tbl.push_back('{'0, '0, '0, RAD_W'(3*ONE/2), 0, '{default: '0}}); // both faces of all axes
    foreach (tbl[i]) send_point(tbl[i]);
    drain();

    // sign flip and extreme boxes
    write_reg(REG_INSIDE_POS, '0);
    foreach (tbl[i]) begin
      rw = tbl[i]; rw.typed = 0; send_point(rw);
    end
    drain();
    write_reg(REG_MIN_X, CMIN); write_reg(REG_MIN_Y, CMIN); write_reg(REG_MIN_Z, CMIN);
    write_reg(REG_MAX_X, CMAX); write_reg(REG_MAX_Y, CMAX); write_reg(REG_MAX_Z, CMAX);
    write_reg(REG_INSIDE_POS, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) begin
      rw = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_rad(), 0, '{default: '0}};
      send_point(rw);
    end
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      for (int a = 0; a < 3; a++) begin
        lo = ($urandom_range(0, 4) == 0) ? $urandom()
             : COORD_BITS'($signed($urandom_range(0, 4 << 16)) - (4 << 16));
        hi = ($urandom_range(0, 4) == 0) ? $urandom() : COORD_BITS'($urandom_range(0, 4 << 16));
        write_reg(reg_idx_t'(a), lo);
        write_reg(reg_idx_t'(a + 3), hi);
      end
      write_reg(REG_INSIDE_POS, $urandom());
      for (int i = 0; i < 100; i++) begin
        rw = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_rad(), 0, '{default: '0}};
        send_point(rw);
      end
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/asdn_pkg.sv
rtl/asdn_front.sv
rtl/asdn_queue.sv
rtl/asdn_back.sv
rtl/aabb_signed_distance_normal.sv
test/tb.sv
